FILE: design/page_framebuffer_text_renderer_assert.svh
// Assertion macros shared by the framebuffer renderer RTL.
`ifndef PAGE_FRAMEBUFFER_TEXT_RENDERER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PFTR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFTR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/pftr_pkg.sv
// Constants, opcodes and the 5x7 font for the framebuffer renderer.
package pftr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int FONT_SIZE     = 20;
  localparam int FONT_W        = $clog2(FONT_SIZE);

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_CHAR  = 3'd2;
  localparam logic [2:0] OP_BARS  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [39:0] glyph_t;
  typedef logic [FONT_W-1:0] font_idx_t;

  // Returns a hit flag above the font index of the code.
  function automatic logic [FONT_W:0] font_find(input logic [7:0] code);
    logic [FONT_W:0] res;
    case (code)
      8'h30: res = {1'b1, font_idx_t'(0)};
      8'h31: res = {1'b1, font_idx_t'(1)};
      8'h32: res = {1'b1, font_idx_t'(2)};
      8'h33: res = {1'b1, font_idx_t'(3)};
      8'h34: res = {1'b1, font_idx_t'(4)};
      8'h35: res = {1'b1, font_idx_t'(5)};
      8'h36: res = {1'b1, font_idx_t'(6)};
      8'h37: res = {1'b1, font_idx_t'(7)};
      8'h38: res = {1'b1, font_idx_t'(8)};
      8'h39: res = {1'b1, font_idx_t'(9)};
      8'h53: res = {1'b1, font_idx_t'(10)};
      8'h50: res = {1'b1, font_idx_t'(11)};
      8'h4D: res = {1'b1, font_idx_t'(12)};
      8'h52: res = {1'b1, font_idx_t'(13)};
      8'h45: res = {1'b1, font_idx_t'(14)};
      8'h43: res = {1'b1, font_idx_t'(15)};
      8'h47: res = {1'b1, font_idx_t'(16)};
      8'h3A: res = {1'b1, font_idx_t'(17)};
      8'h2E: res = {1'b1, font_idx_t'(18)};
      8'h2D: res = {1'b1, font_idx_t'(19)};
      default: res = '0;
    endcase
    return res;
  endfunction

  // Column c of the glyph sits in bits [8c+7:8c]; bit r of a column is row r.
  function automatic glyph_t font_glyph(input font_idx_t idx);
    glyph_t g;
    case (idx)
      font_idx_t'(0):  g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      font_idx_t'(1):  g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      font_idx_t'(2):  g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      font_idx_t'(3):  g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      font_idx_t'(4):  g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      font_idx_t'(5):  g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      font_idx_t'(6):  g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      font_idx_t'(7):  g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      font_idx_t'(8):  g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      font_idx_t'(9):  g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      font_idx_t'(10): g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      font_idx_t'(11): g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      font_idx_t'(12): g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      font_idx_t'(13): g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      font_idx_t'(14): g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      font_idx_t'(15): g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      font_idx_t'(16): g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      font_idx_t'(17): g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      font_idx_t'(18): g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      font_idx_t'(19): g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      default:         g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: design/page_framebuffer_text_renderer.sv
// Page-layout monochrome framebuffer with pixel, glyph, bar and read commands.
// One item is in work at a time. A glyph or bar visits each pixel position of its
// cell in ST_GEN; each enabled on-screen pixel reads its store byte there and writes
// it back in ST_WR. Reset runs a clearing pass over all 1024 store bytes with
// in_stall high.
`include "page_framebuffer_text_renderer_assert.svh"

module page_framebuffer_text_renderer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [8:0] x_pos,
  input  logic [8:0] y_pos,
  input  logic       pixel_on,
  input  logic [7:0] char_code,
  input  logic [2:0] scale,
  input  logic [2:0] level,
  input  logic [9:0] read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data
);
  import pftr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_GEN  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_RD2  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [7:0] frame_store [STORE_BYTES];

  logic [2:0]      state;
  logic            clr_reply;
  addr_t           sweep;
  logic [2:0]      op;
  logic [8:0]      x;
  logic [8:0]      y;
  logic            on;
  logic [2:0]      s;
  logic [1:0]      lvl;
  font_idx_t       gl_idx;
  logic [9:0]      ridx;
  logic [7:0]      res_data;
  logic [2:0]      gc;
  logic [2:0]      gr;
  logic [1:0]      gdx;
  logic [3:0]      gdy;
  addr_t           wr_addr;
  logic [7:0]      wr_mask;
  logic            wr_on;
  logic [7:0]      rd_data;

  logic            accept;
  logic [FONT_W:0] find;
  logic [2:0]      s_clamp;
  logic [7:0]      col_bits;
  logic [5:0]      off_x;
  logic [5:0]      off_y;
  logic [9:0]      px;
  logic [9:0]      py;
  logic            pt_en;
  logic            pt_on;
  logic            in_screen;
  addr_t           pt_addr;
  logic            dy_last;
  logic            dx_last;
  logic            r_last;
  logic            c_last;
  logic            mem_we;
  addr_t           mem_waddr;
  logic [7:0]      mem_wdata;
  addr_t           mem_raddr;
  logic            ridx_ok;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign find     = font_find(char_code);
  assign s_clamp  = (scale > 3'd4) ? 3'd4 : scale;
  assign col_bits = 8'(font_glyph(gl_idx) >> {gc, 3'b000});

  always_comb begin
    off_x   = '0;
    off_y   = '0;
    px      = {x[8], x};
    py      = {y[8], y};
    pt_en   = 1'b1;
    pt_on   = on;
    dy_last = 1'b1;
    dx_last = 1'b1;
    r_last  = 1'b1;
    c_last  = 1'b1;
    case (op)
      OP_CHAR: begin
        off_x   = 6'(6'(gc) * 6'(s)) + 6'(gdx);
        off_y   = 6'(6'(gr) * 6'(s)) + 6'(gdy);
        px      = {x[8], x} + {4'd0, off_x};
        py      = {y[8], y} + {4'd0, off_y};
        pt_en   = col_bits[gr];
        pt_on   = 1'b1;
        dy_last = (gdy == 4'(s - 3'd1));
        dx_last = (gdx == 2'(s - 3'd1));
        r_last  = (gr == 3'd6);
        c_last  = (gc == 3'd4);
      end
      OP_BARS: begin
        off_x   = 6'(6'(gc) * 6'd5) + 6'(gdx);
        px      = {x[8], x} + {4'd0, off_x};
        py      = {y[8], y} - {6'd0, gdy};
        pt_on   = ({1'b0, gc[1:0]} < {1'b0, lvl});
        dy_last = (gdy == 4'(4'd2 + 4'(gc) * 4'd3));
        dx_last = (gdx == 2'd2);
        c_last  = (gc == 3'd2);
      end
      default: begin
      end
    endcase
  end

  assign in_screen = !px[9] && (px < 10'(SCREEN_WIDTH))
                  && !py[9] && (py < 10'(SCREEN_HEIGHT));
  assign pt_addr   = addr_t'(px) + addr_t'(SCREEN_WIDTH) * addr_t'(py >> 3);
  assign ridx_ok   = ({22'd0, ridx} < 32'(STORE_BYTES));

  assign mem_we    = (state == ST_CLR) || (state == ST_WR);
  assign mem_waddr = (state == ST_CLR) ? sweep : wr_addr;
  assign mem_wdata = (state == ST_CLR) ? 8'd0
                   : (wr_on ? (rd_data | wr_mask) : (rd_data & ~wr_mask));
  assign mem_raddr = (state == ST_RD) ? addr_t'(ridx) : pt_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
    rd_data <= frame_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_reply <= 1'b0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op       <= opcode;
            x        <= x_pos;
            y        <= y_pos;
            on       <= pixel_on;
            s        <= s_clamp;
            lvl      <= (level > 3'd3) ? 2'd3 : level[1:0];
            gl_idx   <= find[FONT_W-1:0];
            ridx     <= read_index;
            res_data <= 8'd0;
            gc       <= '0;
            gr       <= '0;
            gdx      <= '0;
            gdy      <= '0;
            case (opcode)
              OP_CLEAR: begin
                state     <= ST_CLR;
                clr_reply <= 1'b1;
                sweep     <= '0;
              end
              OP_PIXEL, OP_BARS: state <= ST_GEN;
              OP_CHAR: state <= (find[FONT_W] && s_clamp != 3'd0) ? ST_GEN : ST_DONE;
              OP_READ: state <= ST_RD;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CLR: begin
          sweep <= sweep + addr_t'(1);
          if (sweep == addr_t'(STORE_BYTES - 1)) begin
            state <= clr_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_GEN, ST_WR: begin
          if (state == ST_GEN && pt_en && in_screen) begin
            state   <= ST_WR;
            wr_addr <= pt_addr;
            wr_mask <= 8'(1) << py[2:0];
            wr_on   <= pt_on;
          end else begin
            state <= (dy_last && dx_last && r_last && c_last) ? ST_DONE : ST_GEN;
            if (!dy_last) begin
              gdy <= gdy + 4'd1;
            end else begin
              gdy <= '0;
              if (!dx_last) begin
                gdx <= gdx + 2'd1;
              end else begin
                gdx <= '0;
                if (!r_last) begin
                  gr <= gr + 3'd1;
                end else begin
                  gr <= '0;
                  if (!c_last) begin
                    gc <= gc + 3'd1;
                  end
                end
              end
            end
          end
        end
        ST_RD: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          res_data <= ridx_ok ? rd_data : 8'd0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_data <= res_data;
            clr_reply <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PFTR_ASSERT_NOW(a_we_source, mem_we, (state == ST_CLR || state == ST_WR), "store written outside a write state")
  `PFTR_ASSERT_NEXT(a_accept_busy, accept, in_stall, "block took an item but did not go busy")
  `PFTR_ASSERT_NOW(a_reset_sweep, $past(rst), (state == ST_CLR && sweep == '0), "clearing pass did not start after reset")
  `PFTR_ASSERT_NOW(a_result_src, $rose(out_valid), ($past(state) == ST_DONE), "result item raised outside the done state")

endmodule
